FILE: rtl/rr_sjf_cpu_scheduler_sim_assert.svh
// Assertion macros used by the scheduler RTL.
`ifndef RR_SJF_CPU_SCHEDULER_SIM_ASSERT_SVH
`define RR_SJF_CPU_SCHEDULER_SIM_ASSERT_SVH

// Condition implies a consequence in the same cycle.
`define RRSJF_ASSERT_NOW(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Condition implies a consequence in the next cycle.
`define RRSJF_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rrsjf_pkg.sv
package rrsjf_pkg;

	localparam int MAX_PROCS = 32;
	localparam int PIDX_W    = 5;
	localparam int CNT_W     = 6;
	localparam int WORK_W    = 22;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic MODE_RR  = 1'b0;
	localparam logic MODE_SJF = 1'b1;

	localparam logic REG_MODE    = 1'b0;
	localparam logic REG_QUANTUM = 1'b1;

	typedef enum logic [1:0] {
		ST_ABSENT  = 2'd0,
		ST_READY   = 2'd1,
		ST_RUNNING = 2'd2,
		ST_DONE    = 2'd3
	} status_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] arrival_time;
		logic [15:0] burst_length;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] tick_time;
		logic        running_valid;
		logic [4:0]  running_process;
		logic [5:0]  ready_count;
		logic        is_wait_report;
		logic [4:0]  report_process;
		logic [31:0] wait_total;
		logic        last;
	} out_beat_t;

	// Broadcast command from the sequencer to the row of cells.
	typedef struct packed {
		logic              load;
		logic              set_st;
		logic              dec;
		logic              wait_inc;
		logic [PIDX_W-1:0] idx;
		status_t           st;
		logic [15:0]       arr;
		logic [15:0]       rem;
	} cell_cmd_t;

	// Running minimum and ready count handed from cell to cell.
	typedef struct packed {
		logic              found;
		logic [PIDX_W-1:0] best;
		logic [15:0]       best_rem;
		logic [CNT_W-1:0]  rdy_cnt;
	} chain_t;

endpackage

FILE: rtl/rr_sjf_cpu_scheduler_sim.sv
// A load beat returns nothing. A tick beat scans the arrivals, then retires, preempts or charges
// the running process; round robin reads the ready queue and shortest job first sweeps the cell
// row before a dispatch; then waits are bumped and the cell row settles before the tick result
// is shown. The cell row carries the search and the ready count through a register in each cell.
// Throughput: one beat at a time; the next beat is taken after all results left, and wait
// reports follow one per cycle while the output does not stall. Reset (arst_n low, asynchronous):
// no process loaded, time zero, CPU idle, round robin with a quantum of one.
`include "rr_sjf_cpu_scheduler_sim_assert.svh"

module rr_sjf_cpu_scheduler_sim
	import rrsjf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// The sequencer walks one tick through its phases: arrivals are scanned one
	// entry per cycle, the running process is retired, preempted or charged,
	// a new one is dispatched, waits are bumped and the cell row is given time
	// to settle before the tick result is shown.
	typedef enum logic [3:0] {
		S_IDLE, S_ARRIVE, S_RUN, S_FIFO_RD, S_SJF, S_DISP,
		S_WINC, S_COUNT, S_TICK_OUT, S_REP_OUT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   scan_q;
	logic [WORK_W-1:0]  work_q;
	logic [31:0]        tick_q;
	logic [PIDX_W-1:0]  cur_q;
	logic               cur_valid_q;
	logic [15:0]        slice_q;
	logic [PIDX_W-1:0]  head_q;
	logic [CNT_W-1:0]   fill_q;
	logic               mode_q;
	logic [15:0]        quantum_q;
	logic [CNT_W-1:0]   sweep_q;
	logic [PIDX_W-1:0]  rep_q;
	logic [PIDX_W-1:0]  fifo_mem [MAX_PROCS];
	logic [PIDX_W-1:0]  fifo_rd_q;

	cell_cmd_t          cmd;
	chain_t             chain [MAX_PROCS+1];
	logic [15:0]        arr_a  [MAX_PROCS];
	logic [15:0]        rem_a  [MAX_PROCS];
	status_t            st_a   [MAX_PROCS];
	logic [31:0]        wait_a [MAX_PROCS];

	logic               in_acc;
	logic               out_acc;
	logic               scan_live;
	logic [15:0]        scan_arr;
	logic               arr_now;
	logic               arr_later;
	logic               cur_rem0;
	logic               preempt;
	logic               disp_go;
	logic [PIDX_W-1:0]  disp_p;
	logic               reports_due;
	logic               push_en;
	logic [PIDX_W-1:0]  push_p;
	logic [PIDX_W-1:0]  push_addr;
	logic               pop_en;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == S_TICK_OUT) || (state_q == S_REP_OUT);
	assign out_acc   = out_valid && !out_stall;

	assign scan_live  = (scan_q < count_q);
	assign scan_arr   = arr_a[scan_q[PIDX_W-1:0]];
	assign arr_now    = ({16'd0, scan_arr} == tick_q);
	assign arr_later  = ({16'd0, scan_arr} > tick_q);
	assign cur_rem0   = (rem_a[cur_q] == 16'd0);
	assign preempt    = (mode_q == MODE_RR) && (slice_q == 16'd0);
	assign disp_go    = (mode_q == MODE_RR) ? (fill_q != '0) : chain[MAX_PROCS].found;
	assign disp_p     = (mode_q == MODE_RR) ? fifo_rd_q : chain[MAX_PROCS].best;
	assign reports_due = (work_q == '0) && (count_q != '0);

	// FIFO pushes come from arrivals in round-robin mode and from preemption.
	always_comb begin
		push_en = 1'b0;
		push_p  = cur_q;
		if ((state_q == S_ARRIVE) && scan_live && arr_now && (mode_q == MODE_RR)) begin
			push_en = 1'b1;
			push_p  = scan_q[PIDX_W-1:0];
		end else if ((state_q == S_RUN) && cur_valid_q && !cur_rem0 && preempt) begin
			push_en = 1'b1;
		end
	end
	assign push_addr = head_q + fill_q[PIDX_W-1:0];
	assign pop_en    = (state_q == S_DISP) && disp_go && (mode_q == MODE_RR);

	always_ff @(posedge clk) begin
		if (push_en && (fill_q < CNT_W'(MAX_PROCS))) begin
			fifo_mem[push_addr] <= push_p;
		end
		fifo_rd_q <= fifo_mem[head_q];
	end

	// Broadcast to the cells.
	always_comb begin
		cmd          = '0;
		cmd.st       = ST_ABSENT;
		cmd.arr      = in_data.arrival_time;
		cmd.rem      = in_data.burst_length;
		cmd.idx      = cur_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.idx  = count_q[PIDX_W-1:0];
				cmd.load = in_acc && (in_data.operation == OP_LOAD) &&
					(count_q < CNT_W'(MAX_PROCS));
			end
			S_ARRIVE: begin
				cmd.idx    = scan_q[PIDX_W-1:0];
				cmd.set_st = scan_live && arr_now;
				cmd.st     = ST_READY;
			end
			S_RUN: begin
				if (cur_valid_q) begin
					if (cur_rem0) begin
						cmd.set_st = 1'b1;
						cmd.st     = ST_DONE;
					end else if (preempt) begin
						cmd.set_st = 1'b1;
						cmd.st     = ST_READY;
					end else begin
						cmd.dec = 1'b1;
					end
				end
			end
			S_DISP: begin
				cmd.idx    = disp_p;
				cmd.set_st = disp_go;
				cmd.st     = ST_RUNNING;
				cmd.dec    = disp_go;
			end
			S_WINC: begin
				cmd.wait_inc = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign chain[0] = '0;

	for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
		rrsjf_cell #(
			.INDEX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.chain_in (chain[g]),
			.chain_out(chain[g+1]),
			.arr      (arr_a[g]),
			.rem      (rem_a[g]),
			.st       (st_a[g]),
			.wait_cnt (wait_a[g])
		);
	end

	// The result beat is built from held state, so it stays put while stalled.
	always_comb begin
		out_data = '0;
		if (state_q == S_REP_OUT) begin
			out_data.tick_time      = tick_q;
			out_data.is_wait_report = 1'b1;
			out_data.report_process = rep_q;
			out_data.wait_total     = wait_a[rep_q];
			out_data.last           = ({1'b0, rep_q} == (count_q - CNT_W'(1)));
		end else begin
			out_data.tick_time       = tick_q;
			out_data.running_valid   = cur_valid_q;
			out_data.running_process = cur_valid_q ? cur_q : '0;
			out_data.ready_count     = chain[MAX_PROCS].rdy_cnt;
			out_data.last            = !reports_due;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			work_q      <= '0;
			tick_q      <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			slice_q     <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			mode_q      <= MODE_RR;
			quantum_q   <= 16'd1;
			sweep_q     <= '0;
			rep_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE:    mode_q    <= cfg_data[0];
					REG_QUANTUM: quantum_q <= cfg_data;
				endcase
			end
			if (push_en && (fill_q < CNT_W'(MAX_PROCS))) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (pop_en) begin
				head_q <= head_q + PIDX_W'(1);
				fill_q <= fill_q - CNT_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_data.operation == OP_LOAD) begin
							if (count_q < CNT_W'(MAX_PROCS)) begin
								count_q <= count_q + CNT_W'(1);
								work_q  <= work_q + WORK_W'(in_data.burst_length);
							end
						end else if (work_q != '0) begin
							state_q <= S_ARRIVE;
						end else if (count_q != '0) begin
							rep_q   <= '0;
							state_q <= S_REP_OUT;
						end
					end
				end
				S_ARRIVE: begin
					if (!scan_live || arr_later) begin
						state_q <= S_RUN;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				S_RUN: begin
					sweep_q <= '0;
					if (cur_valid_q && !cur_rem0 && !preempt) begin
						work_q <= work_q - WORK_W'(1);
						if (slice_q != 16'd0) begin
							slice_q <= slice_q - 16'd1;
						end
						state_q <= S_WINC;
					end else begin
						cur_valid_q <= 1'b0;
						state_q     <= (mode_q == MODE_RR) ? S_FIFO_RD : S_SJF;
					end
				end
				S_FIFO_RD: begin
					state_q <= S_DISP;
				end
				S_SJF: begin
					sweep_q <= sweep_q + CNT_W'(1);
					if (sweep_q == CNT_W'(MAX_PROCS - 1)) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (disp_go) begin
						cur_q       <= disp_p;
						cur_valid_q <= 1'b1;
						slice_q     <= (quantum_q == 16'd0) ? 16'd0 : quantum_q - 16'd1;
						if (rem_a[disp_p] != 16'd0) begin
							work_q <= work_q - WORK_W'(1);
						end
					end
					state_q <= S_WINC;
				end
				S_WINC: begin
					sweep_q <= '0;
					state_q <= S_COUNT;
				end
				S_COUNT: begin
					sweep_q <= sweep_q + CNT_W'(1);
					if (sweep_q == CNT_W'(MAX_PROCS - 1)) begin
						state_q <= S_TICK_OUT;
					end
				end
				S_TICK_OUT: begin
					if (out_acc) begin
						if (tick_q != 32'hFFFF_FFFF) begin
							tick_q <= tick_q + 32'd1;
						end
						rep_q   <= '0;
						state_q <= reports_due ? S_REP_OUT : S_IDLE;
					end
				end
				S_REP_OUT: begin
					if (out_acc) begin
						if ({1'b0, rep_q} == (count_q - CNT_W'(1))) begin
							state_q <= S_IDLE;
						end else begin
							rep_q <= rep_q + PIDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`RRSJF_ASSERT_NOW(a_cur_running, (state_q == S_IDLE) && cur_valid_q,
		st_a[cur_q] == ST_RUNNING, "current process is not marked running")
	`RRSJF_ASSERT_NOW(a_fifo_bound, 1'b1, fill_q <= CNT_W'(MAX_PROCS),
		"ready queue fill exceeds its depth")
	`RRSJF_ASSERT_NOW(a_rep_range, state_q == S_REP_OUT, CNT_W'(rep_q) < count_q,
		"wait report index beyond loaded processes")
	`RRSJF_ASSERT_NEXT(a_load_quiet, in_acc && (in_data.operation == OP_LOAD),
		!out_valid, "load beat produced a result")

endmodule

FILE: rtl/rrsjf_cell.sv
module rrsjf_cell
	import rrsjf_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cell_cmd_t   cmd,
	input  chain_t      chain_in,
	output chain_t      chain_out,
	output logic [15:0] arr,
	output logic [15:0] rem,
	output status_t     st,
	output logic [31:0] wait_cnt
);

	logic [15:0] arr_q;
	logic [15:0] rem_q;
	status_t     st_q;
	logic [31:0] wait_q;
	chain_t      chain_q;
	logic        hit;
	logic        rdy;
	logic        take;

	assign hit  = (cmd.idx == PIDX_W'(INDEX));
	assign rdy  = (st_q == ST_READY);
	// Strict compare keeps the lower index on ties.
	assign take = rdy && (!chain_in.found || (rem_q < chain_in.best_rem));

	always_ff @(posedge clk) begin
		if (cmd.load && hit) begin
			arr_q <= cmd.arr;
			rem_q <= cmd.rem;
		end else if (cmd.dec && hit && (rem_q != 16'd0)) begin
			rem_q <= rem_q - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_ABSENT;
			wait_q  <= '0;
			chain_q <= '0;
		end else begin
			if (cmd.load && hit) begin
				st_q   <= ST_ABSENT;
				wait_q <= '0;
			end else begin
				if (cmd.set_st && hit) begin
					st_q <= cmd.st;
				end
				if (cmd.wait_inc && rdy && (wait_q != 32'hFFFF_FFFF)) begin
					wait_q <= wait_q + 32'd1;
				end
			end
			chain_q.found    <= chain_in.found || take;
			chain_q.best     <= take ? PIDX_W'(INDEX) : chain_in.best;
			chain_q.best_rem <= take ? rem_q : chain_in.best_rem;
			chain_q.rdy_cnt  <= chain_in.rdy_cnt + CNT_W'(rdy);
		end
	end

	assign chain_out = chain_q;
	assign arr       = arr_q;
	assign rem       = rem_q;
	assign st        = st_q;
	assign wait_cnt  = wait_q;

endmodule

FILE: test/tb_rr_sjf_cpu_scheduler_sim.sv
`timescale 1ns / 1ps

module tb_rr_sjf_cpu_scheduler_sim
	import rrsjf_pkg::*;
;

	// Scoreboard: holds its own copy of the scheduler state, works out the
	// results that each accepted input beat causes, and checks output beats
	// against them in order.
	class sched_scoreboard;
		out_beat_t   expected_q[$];
		int          errors;
		logic [15:0] arr_tbl [MAX_PROCS];
		logic [15:0] burst_left [MAX_PROCS];
		status_t     status [MAX_PROCS];
		logic [31:0] waited [MAX_PROCS];
		logic [4:0]  rr_queue [MAX_PROCS];
		int          rr_head;
		int          rr_fill;
		int          cpu_proc;
		bit          cpu_busy;
		int          slice_rem;
		logic [31:0] now_tick;
		int          scan_pos;
		int          loaded;
		int          work;
		logic        mode;
		logic [15:0] quantum;

		function new();
			errors = 0;
			rr_head = 0;
			rr_fill = 0;
			cpu_proc = 0;
			cpu_busy = 0;
			slice_rem = 0;
			now_tick = 0;
			scan_pos = 0;
			loaded = 0;
			work = 0;
			mode = MODE_RR;
			quantum = 16'd1;
			for (int i = 0; i < MAX_PROCS; i++) begin
				status[i] = ST_ABSENT;
				waited[i] = 0;
			end
		endfunction

		function void set_reg(logic idx, logic [15:0] val);
			if (idx == REG_MODE)
				mode = val[0];
			else
				quantum = val;
		endfunction

		function void rr_push(int p);
			if (rr_fill < MAX_PROCS) begin
				rr_queue[(rr_head + rr_fill) % MAX_PROCS] = p[4:0];
				rr_fill++;
			end
		endfunction

		function void run_proc(int p);
			cpu_proc = p;
			cpu_busy = 1;
			status[p] = ST_RUNNING;
			slice_rem = (quantum == 0) ? 0 : int'(quantum) - 1;
			if (burst_left[p] != 0) begin
				burst_left[p]--;
				work--;
			end
		endfunction

		function void pick_next();
			int best;
			bit found;
			found = 0;
			best = 0;
			if (mode == MODE_RR) begin
				if (rr_fill != 0) begin
					best = rr_queue[rr_head];
					rr_head = (rr_head + 1) % MAX_PROCS;
					rr_fill--;
					run_proc(best);
				end
			end else begin
				for (int i = 0; i < loaded; i++) begin
					if (status[i] == ST_READY && (!found || burst_left[i] < burst_left[best])) begin
						best = i;
						found = 1;
					end
				end
				if (found)
					run_proc(best);
			end
		endfunction

		function void advance_tick();
			while (scan_pos < loaded) begin
				if ({16'd0, arr_tbl[scan_pos]} == now_tick) begin
					status[scan_pos] = ST_READY;
					if (mode == MODE_RR)
						rr_push(scan_pos);
				end
				if ({16'd0, arr_tbl[scan_pos]} > now_tick)
					break;
				scan_pos++;
			end
			if (cpu_busy) begin
				if (burst_left[cpu_proc] == 0) begin
					status[cpu_proc] = ST_DONE;
					cpu_busy = 0;
					pick_next();
				end else if (mode == MODE_RR && slice_rem == 0) begin
					status[cpu_proc] = ST_READY;
					cpu_busy = 0;
					rr_push(cpu_proc);
					pick_next();
				end else begin
					burst_left[cpu_proc]--;
					work--;
					if (slice_rem != 0)
						slice_rem--;
				end
			end else begin
				pick_next();
			end
			for (int i = 0; i < loaded; i++)
				if (status[i] == ST_READY && waited[i] != 32'hFFFF_FFFF)
					waited[i]++;
		endfunction

		function void note_input(in_beat_t b);
			out_beat_t res[$];
			out_beat_t r;
			int nready;
			if (b.operation == OP_LOAD) begin
				if (loaded < MAX_PROCS) begin
					arr_tbl[loaded] = b.arrival_time;
					burst_left[loaded] = b.burst_length;
					status[loaded] = ST_ABSENT;
					waited[loaded] = 0;
					loaded++;
					work += b.burst_length;
				end
				return;
			end
			if (work != 0) begin
				advance_tick();
				nready = 0;
				for (int i = 0; i < loaded; i++)
					if (status[i] == ST_READY)
						nready++;
				r = '0;
				r.tick_time = now_tick;
				r.running_valid = cpu_busy;
				r.running_process = cpu_busy ? cpu_proc[4:0] : 5'd0;
				r.ready_count = nready[5:0];
				res.push_back(r);
				if (now_tick != 32'hFFFF_FFFF)
					now_tick++;
			end
			if (work == 0) begin
				for (int i = 0; i < loaded; i++) begin
					r = '0;
					r.tick_time = now_tick;
					r.is_wait_report = 1'b1;
					r.report_process = i[4:0];
					r.wait_total = waited[i];
					res.push_back(r);
				end
			end
			if (res.size() > 0)
				res[res.size() - 1].last = 1'b1;
			foreach (res[i])
				expected_q.push_back(res[i]);
		endfunction

		function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0d, got %0d", field, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(out_beat_t got);
			out_beat_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected output beat %h", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare("tick_time", e.tick_time, got.tick_time);
			compare("running_valid", e.running_valid, got.running_valid);
			compare("running_process", e.running_process, got.running_process);
			compare("ready_count", e.ready_count, got.ready_count);
			compare("is_wait_report", e.is_wait_report, got.is_wait_report);
			compare("report_process", e.report_process, got.report_process);
			compare("wait_total", e.wait_total, got.wait_total);
			compare("last", e.last, got.last);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_beat_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_beat_t   out_data;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	sched_scoreboard sb;
	// When set, the input side sends back to back with no gaps.
	bit          no_gaps;

	rr_sjf_cpu_scheduler_sim dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	// The output side stalls at random in the same way. Time is split into
	// stretches; one in three is stall-free and the other two use the stalling
	// pattern, so both regimes hit every phase of a tick.
	int stall_left;
	int cyc;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else if ((cyc / 500) % 3 != 0 && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				stall_left <= pick_gap();
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Sends one beat and returns at the edge where it was accepted. The
	// valid line stays high across back-to-back beats.
	task automatic send_beat(in_beat_t b);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		sb.note_input(b);
	endtask

	task automatic load_proc(logic [15:0] arrival, logic [15:0] burst);
		in_beat_t b;
		b.operation = OP_LOAD;
		b.arrival_time = arrival;
		b.burst_length = burst;
		send_beat(b);
	endtask

	// The fields other than the operation are don't-care on a tick, so they
	// carry random bits.
	task automatic tick_once();
		in_beat_t b;
		b = in_beat_t'({$urandom, $urandom});
		b.operation = OP_TICK;
		send_beat(b);
	endtask

	// Waits for every expected beat to leave, then for the worst tick
	// latency, so a tick that produced nothing has finished too.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// Ticks until the table has no work left, then a couple more to see the
	// wait reports repeat.
	task automatic run_to_drain();
		int guard;
		guard = 0;
		while (sb.work != 0 && guard < 400) begin
			tick_once();
			guard++;
		end
		tick_once();
		tick_once();
	endtask

	task automatic load_group(int count);
		logic [31:0] at;
		at = sb.now_tick;
		for (int i = 0; i < count; i++) begin
			at += $urandom_range(0, 3);
			load_proc(at[15:0], (i == 0) ? 16'd0 : 16'($urandom_range(0, 5)));
		end
	endtask

	initial begin
		in_beat_t b;
		logic [15:0] qv;
		sb = new();
		no_gaps = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A tick with nothing loaded reports nothing at all.
		tick_once();
		settle();

		// Six phases alternating round robin and shortest job first, each
		// loading five processes at or after the current time. The quantum runs
		// over its extremes, zero included, which acts as a slice of one.
		for (int ph = 0; ph < 6; ph++) begin
			no_gaps = (ph == 3);
			case (ph)
				0: qv = 16'd1;
				2: qv = 16'd0;
				4: qv = 16'hFFFF;
				default: qv = 16'($urandom_range(2, 4));
			endcase
			write_reg(REG_MODE, (ph % 2 == 1) ? 16'(MODE_SJF) : 16'(MODE_RR));
			write_reg(REG_QUANTUM, qv);
			load_group(5);
			if (ph == 4) begin
				// Switching to shortest job first while work is pending.
				repeat (4) tick_once();
				settle();
				write_reg(REG_MODE, 16'(MODE_SJF));
			end
			run_to_drain();
			settle();
		end
		no_gaps = 0;

		// Last two slots: late entries whose arrival is already past. The
		// first has no burst and still gets a report; the second never
		// drains, so from then on each tick reports an idle CPU.
		write_reg(REG_QUANTUM, 16'd2);
		load_proc(16'd0, 16'd0);
		tick_once();
		tick_once();
		load_proc(16'd1, 16'hFFFF);
		tick_once();

		// The table is now full: loads with any field values are ignored.
		load_proc(16'hFFFF, 16'hFFFF);
		load_proc(16'h0000, 16'h0000);
		for (int i = 0; i < 200; i++) begin
			b = in_beat_t'({$urandom, $urandom});
			send_beat(b);
		end
		settle();

		if (sb.expected_q.size() != 0) begin
			$error("%0d expected beats never arrived", sb.expected_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
